/* hw/rtl/tsec_pkg.sv */
// Shared types, character codes and register indexes for the tab stop expander/compressor.
`default_nettype none

package tsec_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IVL_W       = 7;
  localparam int STOP_COLS   = 128;
  localparam int STOP_COL_W  = $clog2(STOP_COLS);
  localparam int SCAN_CHUNK  = 8;
  localparam int SCAN_IDX_W  = $clog2(SCAN_CHUNK);
  localparam int CHUNK_W     = STOP_COL_W - SCAN_IDX_W;

  localparam logic [STOP_COL_W-1:0] LAST_STOP_COL = 7'd127;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic MODE_EXPAND   = 1'b0;
  localparam logic MODE_COMPRESS = 1'b1;

  localparam logic [1:0] STOP_NONE     = 2'd0;
  localparam logic [1:0] STOP_INTERVAL = 2'd1;
  localparam logic [1:0] STOP_BITMAP   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_KIND    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAB_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STOPS_LOW    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STOPS_HIGH   = 3'd4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_char;
  } tsec_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [7:0] repeat_res;
    logic       last_of_run;
  } tsec_out_t;

  typedef struct packed {
    logic                  done;
    logic [IVL_W-1:0]      rem;
  } tsec_div_res_t;

  typedef struct packed {
    logic [STOP_COL_W-1:0] first_col;
    logic [STOP_COL_W-1:0] last_col;
  } tsec_scan_req_t;

  typedef struct packed {
    logic                  done;
    logic                  found;
    logic [STOP_COL_W-1:0] first_col;
    logic [STOP_COL_W-1:0] last_col;
    logic [7:0]            count;
  } tsec_scan_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FI_DIV,
    S_FI_STEP,
    S_FB_SCAN,
    S_F_TABS,
    S_F_SPACES,
    S_ACT,
    S_TW_DIV,
    S_TW_SCAN,
    S_FINAL
  } tsec_state_t;

endpackage

`default_nettype wire

/* hw/rtl/tab_stop_expand_compress_core.sv */
// Top level of the tab stop expander/compressor: sequencer, state, config and output register.
`default_nettype none

// Takes one item (a text byte or an end-of-line mark) at a time and returns up to three runs
// (character plus repeat count), the last one flagged. in_ready is high only while the sequencer
// is idle. In expand mode a plain character, backspace or end of line passes the decode, act and
// final states before the next accept, its result landing in the output register from the final
// state. A tab with interval stops adds a pass of the shared bit-serial remainder unit; a
// tab with bitmap stops below the last bitmap column adds a run of the stop scanner over the
// eight-column chunks it covers. In compress mode every item other than a held space also
// passes the tab and space run stages. With interval stops it adds a remainder pass and a step
// check, one step per emitted tab, and another remainder pass for each tab taken once the
// column saturates; with bitmap stops and held spaces it adds one scan of the columns those
// spaces cover, one chunk at a time.
// Each emitted run waits for the output register to free up. Held spaces return nothing and
// pass only the decode state. No clearing pass is needed.
module tab_stop_expand_compress_core
  import tsec_pkg::*;
#(
  parameter int COLUMN_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire tsec_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tsec_out_t                   out_data,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SUM_W = ((COLUMN_BITS > 8) ? COLUMN_BITS : 8) + 1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX   = {COLUMN_BITS{1'b1}};
  localparam logic [SUM_W-1:0]       COL_MAX_W = SUM_W'(COL_MAX);

  function automatic logic [COLUMN_BITS-1:0] sat_add(input logic [COLUMN_BITS-1:0] c,
                                                     input logic [7:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(c) + SUM_W'(n);
    return (s > COL_MAX_W) ? COL_MAX : s[COLUMN_BITS-1:0];
  endfunction

  // configuration
  logic                  mode_r;
  logic [1:0]            stop_kind_r;
  logic [IVL_W-1:0]      tab_interval_r;
  logic [CFG_DATA_W-1:0] stops_low_r;
  logic [CFG_DATA_W-1:0] stops_high_r;

  // sequencer and datapath
  tsec_state_t            state_r, state_nxt;
  tsec_in_t               item_r, item_nxt;
  logic [COLUMN_BITS-1:0] column_r, column_nxt;
  logic [7:0]             pending_r, pending_nxt;
  logic [7:0]             sp_r, sp_nxt;
  logic [7:0]             tabs_r, tabs_nxt;
  logic [IVL_W-1:0]       m_r, m_nxt;
  logic [7:0]             fin_char_r, fin_char_nxt;
  logic [7:0]             fin_rep_r, fin_rep_nxt;
  logic                   out_valid_r;
  tsec_out_t              out_data_r;
  logic                   push;
  tsec_out_t              push_data;
  logic                   push_ok;

  logic                   stops_on;
  logic [IVL_W-1:0]       ivl;
  logic [STOP_COLS-1:0]   bitmap;
  logic                   col_in_map;
  logic                   col_below_last;
  logic                   col_is_stop;
  logic                   is_eol, is_bs, is_tab, is_space;
  logic                   hold_space;

  logic [8:0]             flush_lim;
  logic [STOP_COL_W-1:0]  fb_last;
  logic                   fb_empty;
  logic [8:0]             fb_sp;

  logic [IVL_W-1:0]       fi_n;
  logic [SUM_W-1:0]       fi_sum;
  logic                   fi_fits;
  logic                   fi_sat;

  logic [IVL_W-1:0]       tab_n;
  logic                   tab_direct;
  logic                   tab_drop;
  logic [COLUMN_BITS-1:0] tab_col;
  logic [7:0]             tab_char;
  logic [7:0]             tab_rep;

  logic                   div_start;
  tsec_div_res_t          div_res;
  logic                   scan_start;
  tsec_scan_req_t         scan_req;
  tsec_scan_res_t         scan_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_EXPAND;
      stop_kind_r    <= STOP_INTERVAL;
      tab_interval_r <= 7'd8;
      stops_low_r    <= '0;
      stops_high_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:         mode_r         <= cfg_wdata[0];
        REG_STOP_KIND:    stop_kind_r    <= cfg_wdata[1:0];
        REG_TAB_INTERVAL: tab_interval_r <= cfg_wdata[IVL_W-1:0];
        REG_STOPS_LOW:    stops_low_r    <= cfg_wdata;
        REG_STOPS_HIGH:   stops_high_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign stops_on       = (stop_kind_r == STOP_INTERVAL) || (stop_kind_r == STOP_BITMAP);
  assign ivl            = (tab_interval_r == '0) ? IVL_W'(1) : tab_interval_r;
  assign bitmap         = {stops_high_r, stops_low_r};
  assign col_in_map     = column_r <= COLUMN_BITS'(LAST_STOP_COL);
  assign col_below_last = column_r < COLUMN_BITS'(LAST_STOP_COL);
  // column zero never counts as a stop
  assign col_is_stop    = (column_r != '0) && col_in_map && bitmap[column_r[STOP_COL_W-1:0]];

  assign is_eol     = item_r.cmd == CMD_EOL;
  assign is_bs      = item_r.in_char == CHAR_BS;
  assign is_tab     = item_r.in_char == CHAR_TAB;
  assign is_space   = item_r.in_char == CHAR_SPACE;
  assign hold_space = !is_eol && (mode_r == MODE_COMPRESS) && is_space && stops_on;

  // bitmap flush covers the columns after the current one up to where the held spaces reach
  assign flush_lim = {2'b00, column_r[STOP_COL_W-1:0]} + {1'b0, pending_r};
  assign fb_last   = (flush_lim > 9'(LAST_STOP_COL)) ? LAST_STOP_COL
                                                     : flush_lim[STOP_COL_W-1:0];
  assign fb_empty  = (pending_r == '0) || !col_below_last;
  assign fb_sp     = {2'b00, column_r[STOP_COL_W-1:0]} + {1'b0, sp_r}
                     - {2'b00, scan_res.last_col};

  assign fi_n    = ivl - m_r;
  assign fi_sum  = SUM_W'(column_r) + SUM_W'(fi_n);
  assign fi_fits = sp_r >= {1'b0, fi_n};
  assign fi_sat  = fi_sum > COL_MAX_W;

  always_comb begin
    unique case (state_r)
      S_TW_DIV:  tab_n = ivl - div_res.rem;
      S_TW_SCAN: tab_n = scan_res.found ? (scan_res.first_col - column_r[STOP_COL_W-1:0])
                                        : IVL_W'(col_is_stop);
      default:   tab_n = (stop_kind_r == STOP_BITMAP) ? IVL_W'(col_is_stop) : IVL_W'(1);
    endcase
  end

  assign tab_direct = (stop_kind_r != STOP_INTERVAL) &&
                      !((stop_kind_r == STOP_BITMAP) && col_below_last);
  assign tab_drop   = (mode_r == MODE_EXPAND) && (tab_n == '0);
  assign tab_col    = sat_add(column_r, {1'b0, tab_n});
  assign tab_char   = ((mode_r == MODE_COMPRESS) && stops_on) ? CHAR_TAB : CHAR_SPACE;
  assign tab_rep    = (mode_r == MODE_COMPRESS) ? 8'd1 : {1'b0, tab_n};

  assign push_ok = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (hold_space) begin
          state_nxt = S_IDLE;
        end else if (mode_r == MODE_COMPRESS) begin
          if (stop_kind_r == STOP_INTERVAL) state_nxt = S_FI_DIV;
          else if ((stop_kind_r == STOP_BITMAP) && !fb_empty) state_nxt = S_FB_SCAN;
          else state_nxt = S_F_TABS;
        end else begin
          state_nxt = S_ACT;
        end
      end
      S_FI_DIV: begin
        if (div_res.done) state_nxt = S_FI_STEP;
      end
      S_FI_STEP: begin
        if (!fi_fits) state_nxt = S_F_TABS;
        else if (fi_sat) state_nxt = S_FI_DIV;
      end
      S_FB_SCAN: begin
        if (scan_res.done) state_nxt = S_F_TABS;
      end
      S_F_TABS: begin
        if ((tabs_r == '0) || push_ok) state_nxt = S_F_SPACES;
      end
      S_F_SPACES: begin
        if ((sp_r == '0) || push_ok) state_nxt = S_ACT;
      end
      S_ACT: begin
        if (!is_eol && !is_bs && is_tab) begin
          if (tab_direct) state_nxt = tab_drop ? S_IDLE : S_FINAL;
          else if (stop_kind_r == STOP_INTERVAL) state_nxt = S_TW_DIV;
          else state_nxt = S_TW_SCAN;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_TW_DIV: begin
        if (div_res.done) state_nxt = tab_drop ? S_IDLE : S_FINAL;
      end
      S_TW_SCAN: begin
        if (scan_res.done) state_nxt = tab_drop ? S_IDLE : S_FINAL;
      end
      S_FINAL: begin
        if (push_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result pushes
  always_comb begin
    item_nxt     = item_r;
    column_nxt   = column_r;
    pending_nxt  = pending_r;
    sp_nxt       = sp_r;
    tabs_nxt     = tabs_r;
    m_nxt        = m_r;
    fin_char_nxt = fin_char_r;
    fin_rep_nxt  = fin_rep_r;
    push         = 1'b0;
    push_data    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      S_DECODE: begin
        if (hold_space) begin
          if (pending_r != 8'hFF) pending_nxt = pending_r + 8'd1;
        end else if (mode_r == MODE_COMPRESS) begin
          sp_nxt   = pending_r;
          tabs_nxt = '0;
        end
      end
      S_FI_DIV: begin
        if (div_res.done) m_nxt = div_res.rem;
      end
      S_FI_STEP: begin
        // one tab per cycle until the column saturates; a full step ends on a stop: remainder zero
        if (fi_fits) begin
          sp_nxt     = sp_r - {1'b0, fi_n};
          tabs_nxt   = tabs_r + 8'd1;
          m_nxt      = '0;
          column_nxt = fi_sat ? COL_MAX : fi_sum[COLUMN_BITS-1:0];
        end
      end
      S_FB_SCAN: begin
        if (scan_res.done && (scan_res.count != '0)) begin
          tabs_nxt   = scan_res.count;
          sp_nxt     = fb_sp[7:0];
          column_nxt = COLUMN_BITS'(scan_res.last_col);
        end
      end
      S_F_TABS: begin
        if ((tabs_r != '0) && push_ok) begin
          push                  = 1'b1;
          push_data.out_char    = CHAR_TAB;
          push_data.repeat_res  = tabs_r;
          push_data.last_of_run = 1'b0;
        end
      end
      S_F_SPACES: begin
        if (sp_r == '0) begin
          pending_nxt = '0;
        end else if (push_ok) begin
          push                  = 1'b1;
          push_data.out_char    = CHAR_SPACE;
          push_data.repeat_res  = sp_r;
          push_data.last_of_run = 1'b0;
          column_nxt            = sat_add(column_r, sp_r);
          pending_nxt           = '0;
        end
      end
      S_ACT: begin
        if (is_eol) begin
          column_nxt   = '0;
          pending_nxt  = '0;
          fin_char_nxt = CHAR_NL;
          fin_rep_nxt  = 8'd1;
        end else if (is_bs) begin
          if (column_r != '0) column_nxt = column_r - COLUMN_BITS'(1);
          fin_char_nxt = CHAR_BS;
          fin_rep_nxt  = 8'd1;
        end else if (is_tab) begin
          if (tab_direct) begin
            column_nxt   = tab_col;
            fin_char_nxt = tab_char;
            fin_rep_nxt  = tab_rep;
          end
        end else begin
          column_nxt   = sat_add(column_r, 8'd1);
          fin_char_nxt = item_r.in_char;
          fin_rep_nxt  = 8'd1;
        end
      end
      S_TW_DIV: begin
        if (div_res.done) begin
          column_nxt   = tab_col;
          fin_char_nxt = tab_char;
          fin_rep_nxt  = tab_rep;
        end
      end
      S_TW_SCAN: begin
        if (scan_res.done) begin
          column_nxt   = tab_col;
          fin_char_nxt = tab_char;
          fin_rep_nxt  = tab_rep;
        end
      end
      S_FINAL: begin
        if (push_ok) begin
          push                  = 1'b1;
          push_data.out_char    = fin_char_r;
          push_data.repeat_res  = fin_rep_r;
          push_data.last_of_run = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // launch the shared units when entering their wait states
  assign div_start  = ((state_nxt == S_FI_DIV) || (state_nxt == S_TW_DIV)) &&
                      (state_nxt != state_r);
  assign scan_start = ((state_nxt == S_FB_SCAN) || (state_nxt == S_TW_SCAN)) &&
                      (state_nxt != state_r);

  assign scan_req.first_col = column_r[STOP_COL_W-1:0] + STOP_COL_W'(1);
  assign scan_req.last_col  = (state_r == S_DECODE) ? fb_last : LAST_STOP_COL;

  tsec_mod_unit #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (column_nxt),
    .divisor  (ivl),
    .res      (div_res)
  );

  tsec_stop_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .req    (scan_req),
    .bitmap (bitmap),
    .res    (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      column_r    <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      column_r  <= column_nxt;
      pending_r <= pending_nxt;
      if (push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    sp_r       <= sp_nxt;
    tabs_r     <= tabs_nxt;
    m_r        <= m_nxt;
    fin_char_r <= fin_char_nxt;
    fin_rep_r  <= fin_rep_nxt;
    if (push) out_data_r <= push_data;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/tsec_mod_unit.sv */
// Iterative restoring remainder unit: column modulo tab interval, one bit per cycle.
`default_nettype none

module tsec_mod_unit
  import tsec_pkg::*;
#(
  parameter int COLUMN_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [COLUMN_BITS-1:0] dividend,
  input  wire logic [IVL_W-1:0]       divisor,
  output tsec_div_res_t               res
);

  localparam int CNT_W = $clog2(COLUMN_BITS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IVL_W-1:0]       rem_r, rem_nxt;
  logic [COLUMN_BITS-1:0] dvd_r, dvd_nxt;
  logic [IVL_W:0]         trial;
  logic [IVL_W:0]         diff;

  assign trial = {rem_r, dvd_r[COLUMN_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      // subtract the divisor whenever the partial remainder reaches it
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[IVL_W-1:0] : trial[IVL_W-1:0];
      dvd_nxt = {dvd_r[COLUMN_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(COLUMN_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

/* hw/rtl/tsec_stop_scan.sv */
// Bitmap stop scanner: walks a column range eight columns a cycle, finds first/last stop and count.
`default_nettype none

module tsec_stop_scan
  import tsec_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire tsec_scan_req_t       req,
  input  wire logic [STOP_COLS-1:0] bitmap,
  output tsec_scan_res_t            res
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CHUNK_W-1:0]    ci_r, ci_nxt;
  logic [STOP_COL_W-1:0] lo_r, lo_nxt;
  logic [STOP_COL_W-1:0] hi_r, hi_nxt;
  logic                  found_r, found_nxt;
  logic [STOP_COL_W-1:0] first_r, first_nxt;
  logic [STOP_COL_W-1:0] last_r, last_nxt;
  logic [7:0]            count_r, count_nxt;

  logic [SCAN_CHUNK-1:0] chunk;
  logic [SCAN_CHUNK-1:0] masked;
  logic [SCAN_IDX_W:0]   ones;
  logic [SCAN_IDX_W-1:0] low_idx;
  logic [SCAN_IDX_W-1:0] high_idx;

  assign chunk = bitmap[{ci_r, {SCAN_IDX_W{1'b0}}} +: SCAN_CHUNK];

  // keep only the columns inside the requested range
  always_comb begin
    for (int j = 0; j < SCAN_CHUNK; j++) begin
      masked[j] = chunk[j] && ({ci_r, SCAN_IDX_W'(j)} >= lo_r) &&
                  ({ci_r, SCAN_IDX_W'(j)} <= hi_r);
    end
  end

  always_comb begin
    ones     = '0;
    low_idx  = '0;
    high_idx = '0;
    for (int j = SCAN_CHUNK - 1; j >= 0; j--) begin
      if (masked[j]) low_idx = SCAN_IDX_W'(j);
    end
    for (int j = 0; j < SCAN_CHUNK; j++) begin
      if (masked[j]) high_idx = SCAN_IDX_W'(j);
      ones = ones + (SCAN_IDX_W + 1)'(masked[j]);
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    ci_nxt    = ci_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    found_nxt = found_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    if (start) begin
      busy_nxt  = 1'b1;
      ci_nxt    = req.first_col[STOP_COL_W-1:SCAN_IDX_W];
      lo_nxt    = req.first_col;
      hi_nxt    = req.last_col;
      found_nxt = 1'b0;
      count_nxt = '0;
    end else if (busy_r) begin
      count_nxt = count_r + 8'(ones);
      if (masked != '0) begin
        if (!found_r) begin
          found_nxt = 1'b1;
          first_nxt = {ci_r, low_idx};
        end
        last_nxt = {ci_r, high_idx};
      end
      if (ci_r == hi_r[STOP_COL_W-1:SCAN_IDX_W]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        ci_nxt = ci_r + CHUNK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ci_r    <= ci_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    count_r <= count_nxt;
  end

  assign res.done      = done_r;
  assign res.found     = found_r;
  assign res.first_col = first_r;
  assign res.last_col  = last_r;
  assign res.count     = count_r;

endmodule

`default_nettype wire

/* hw/rtl/tsec_checker.sv */
// Port-level checks for the tab stop expander/compressor, bound to the top level.
`default_nettype none

module tsec_checker
  import tsec_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire tsec_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.repeat_res != 8'd0))
    else $error("result with zero repeat count");

  // only flushed tab and space runs come before the last result of an item
  a_mid_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |->
      ((out_data.out_char == CHAR_TAB) || (out_data.out_char == CHAR_SPACE)))
    else $error("non-final result is not a tab or space run");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an accepted item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind tab_stop_expand_compress_core tsec_checker u_tsec_checker (.*);

`default_nettype wire

/* bench/tab_stop_expand_compress_core_test.sv */
// Self-checking bench for the tab stop expander/compressor core: predicts every run, checks order.
module tab_stop_expand_compress_core_test;
  import tsec_pkg::*;

  localparam int COLUMN_BITS   = 8;
  localparam int COL_LIMIT     = (1 << COLUMN_BITS) - 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_CYCLES  = 400;
  localparam int IDLE_PCT      = 31;
  localparam logic [1:0] STOP_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  tsec_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  tsec_out_t              out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  tab_stop_expand_compress_core #(.COLUMN_BITS(COLUMN_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the registers, starting at their reset values
  logic             cfg_mode = MODE_EXPAND;
  logic [1:0]       cfg_kind = STOP_INTERVAL;
  logic [IVL_W-1:0] cfg_ivl  = 7'd8;
  logic [63:0]      cfg_lo   = '0;
  logic [63:0]      cfg_hi   = '0;

  int unsigned col_pos     = 0;
  int unsigned held_spaces = 0;

  tsec_in_t  pending_items[$];
  tsec_out_t expected_runs[$];
  tsec_out_t step_runs[$];

  int queued_count   = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int stall_left     = 0;
  bit in_accepted    = 1'b0;
  bit steady         = 1'b0;
  bit stall_request  = 1'b0;
  bit stall_done     = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned sat_col(int unsigned c);
    return (c > COL_LIMIT) ? COL_LIMIT : c;
  endfunction

  function automatic bit has_stops();
    return (cfg_kind == STOP_INTERVAL) || (cfg_kind == STOP_BITMAP);
  endfunction

  function automatic int unsigned ivl_eff();
    return (cfg_ivl == 0) ? 1 : int'(cfg_ivl);
  endfunction

  // Column zero and columns past the bitmap never hold a stop
  function automatic bit is_stop(int unsigned c);
    if (c == 0 || c > 127) return 1'b0;
    if (c < 64) return cfg_lo[c];
    return cfg_hi[c - 64];
  endfunction

  // Zero stands for no stop ahead
  function automatic int unsigned next_stop(int unsigned c);
    int unsigned s;
    for (s = c + 1; s <= 127; s++)
      if (is_stop(s)) return s;
    return 0;
  endfunction

  function automatic int unsigned tab_advance();
    int unsigned t;
    if (cfg_kind == STOP_INTERVAL) return ivl_eff() - col_pos % ivl_eff();
    if (cfg_kind == STOP_BITMAP) begin
      t = next_stop(col_pos);
      if (is_stop(col_pos)) return (t == 0) ? 1 : t - col_pos;
      return (t == 0) ? 0 : t - col_pos;
    end
    return 1;
  endfunction

  function automatic void add_run(logic [7:0] ch, int unsigned n);
    step_runs.push_back(tsec_out_t'{ch, 8'(n), 1'b0});
  endfunction

  // Turn held spaces into tabs for every stop reached, then leftover spaces
  function automatic void flush_held();
    int unsigned sp;
    int unsigned tabs;
    int unsigned s;
    int unsigned n;
    sp = held_spaces;
    tabs = 0;
    if (cfg_kind == STOP_BITMAP) begin
      forever begin
        s = next_stop(col_pos);
        if (sp == 0 || s == 0 || col_pos + sp < s) break;
        tabs++;
        sp -= s - col_pos;
        col_pos = sat_col(s);
      end
    end else if (cfg_kind == STOP_INTERVAL) begin
      forever begin
        n = ivl_eff() - col_pos % ivl_eff();
        if (sp < n) break;
        tabs++;
        sp -= n;
        col_pos = sat_col(col_pos + n);
      end
    end
    if (tabs != 0) add_run(CHAR_TAB, tabs);
    if (sp != 0) begin
      add_run(CHAR_SPACE, sp);
      col_pos = sat_col(col_pos + sp);
    end
    held_spaces = 0;
  endfunction

  function automatic void predict_runs(tsec_in_t item);
    int unsigned n;
    step_runs.delete();
    if (item.cmd == CMD_EOL) begin
      if (cfg_mode == MODE_COMPRESS) flush_held();
      add_run(CHAR_NL, 1);
      col_pos = 0;
      held_spaces = 0;
    end else if (cfg_mode == MODE_COMPRESS && item.in_char == CHAR_SPACE && has_stops()) begin
      // hold the space until the next byte or the line end
      if (held_spaces < 255) held_spaces++;
    end else begin
      if (cfg_mode == MODE_COMPRESS) flush_held();
      if (item.in_char == CHAR_BS) begin
        if (col_pos > 0) col_pos--;
        add_run(CHAR_BS, 1);
      end else if (item.in_char == CHAR_TAB) begin
        n = tab_advance();
        if (cfg_mode == MODE_COMPRESS) begin
          col_pos = sat_col(col_pos + n);
          add_run(has_stops() ? CHAR_TAB : CHAR_SPACE, 1);
        end else if (n != 0) begin
          add_run(CHAR_SPACE, n);
          col_pos = sat_col(col_pos + n);
        end
      end else begin
        add_run(item.in_char, 1);
        col_pos = sat_col(col_pos + 1);
      end
    end
    if (step_runs.size() > 0) step_runs[step_runs.size() - 1].last_of_run = 1'b1;
    foreach (step_runs[i]) expected_runs.push_back(step_runs[i]);
  endfunction

  // Check results first, then predict for the item taken at this edge
  always @(posedge clk) begin : check_runs
    tsec_out_t want;
    in_accepted = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected run: char %h repeat %0d last %b",
                   out_data.out_char, out_data.repeat_res, out_data.last_of_run);
      end else begin
        want = expected_runs.pop_front();
        if (out_data.out_char !== want.out_char || out_data.repeat_res !== want.repeat_res ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"run mismatch: expected char %h repeat %0d last %b, ",
                      "got char %h repeat %0d last %b"},
                     want.out_char, want.repeat_res, want.last_of_run,
                     out_data.out_char, out_data.repeat_res, out_data.last_of_run);
        end
      end
    end
    if (in_accepted) begin
      predict_runs(in_data);
      accepted_count++;
    end
  end

  // Item driver: hold the payload until taken, idle at random between items
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      if (pending_items.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_request && !stall_done) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void queue_item(tsec_in_t it);
    pending_items.push_back(it);
    queued_count++;
  endfunction

  function automatic void queue_char(logic [7:0] ch);
    queue_item(tsec_in_t'{CMD_CHAR, ch});
  endfunction

  function automatic tsec_in_t rand_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return tsec_in_t'{CMD_CHAR, CHAR_SPACE};
    if (r < 45) return tsec_in_t'{CMD_CHAR, CHAR_TAB};
    if (r < 52) return tsec_in_t'{CMD_CHAR, CHAR_BS};
    if (r < 58) return tsec_in_t'{CMD_EOL, 8'($urandom)};
    return tsec_in_t'{CMD_CHAR, 8'($urandom)};
  endfunction

  function automatic logic [63:0] rand_stops();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(2))
      0: v &= {$urandom, $urandom} & {$urandom, $urandom};
      1: v |= {$urandom, $urandom};
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic apply_config(logic m, logic [1:0] k, logic [IVL_W-1:0] iv,
                              logic [63:0] lo, logic [63:0] hi);
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_STOP_KIND, 64'(k));
    write_reg(REG_TAB_INTERVAL, 64'(iv));
    write_reg(REG_STOPS_LOW, lo);
    write_reg(REG_STOPS_HIGH, hi);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_mode = m;
    cfg_kind = k;
    cfg_ivl  = iv;
    cfg_lo   = lo;
    cfg_hi   = hi;
    @(posedge clk);
  endtask

  // Wait for every item and run, then let items without results finish
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_runs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int p;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: backspace at column zero, byte extremes, tab, line end
    queue_char(CHAR_BS);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(CHAR_TAB);
    queue_char(CHAR_BS);
    queue_item(tsec_in_t'{CMD_EOL, 8'hFF});
    wait_idle();

    // Interval of 64: drive the column into saturation
    apply_config(MODE_EXPAND, STOP_INTERVAL, 7'd64, '0, '0);
    queue_char(8'h78);
    repeat (5) queue_char(CHAR_TAB);
    queue_item(tsec_in_t'{CMD_EOL, 8'h00});
    wait_idle();

    // Bitmap with stops at columns zero and three: skip zero, last stop, no stop ahead
    apply_config(MODE_EXPAND, STOP_BITMAP, 7'd8, 64'h9, '0);
    repeat (3) queue_char(CHAR_TAB);
    queue_item(tsec_in_t'{CMD_EOL, 8'h00});
    wait_idle();

    // Compress: held spaces flushed by a tab and by the line end
    apply_config(MODE_COMPRESS, STOP_INTERVAL, 7'd4, '0, '0);
    queue_char(8'h61);
    repeat (4) queue_char(CHAR_SPACE);
    queue_char(CHAR_TAB);
    queue_char(CHAR_SPACE);
    queue_item(tsec_in_t'{CMD_EOL, 8'h00});
    wait_idle();

    for (p = 0; p < 10; p++) begin
      case (p)
        0: apply_config(MODE_EXPAND, STOP_INTERVAL, 7'd1, rand_stops(), rand_stops());
        1: apply_config(MODE_COMPRESS, STOP_INTERVAL, 7'd64, rand_stops(), rand_stops());
        2: apply_config(MODE_COMPRESS, STOP_BITMAP, 7'd8, rand_stops(), rand_stops());
        3: apply_config(MODE_EXPAND, STOP_BITMAP, 7'd3, '1, '1);
        4: apply_config(MODE_COMPRESS, STOP_NONE, 7'd5, rand_stops(), rand_stops());
        5: apply_config(MODE_COMPRESS, STOP_INTERVAL, 7'd0, '0, '0);
        6: apply_config(MODE_EXPAND, STOP_UNUSED, 7'd127, rand_stops(), rand_stops());
        7: apply_config(MODE_COMPRESS, STOP_BITMAP, 7'd8, '0, '0);
        default: apply_config(1'($urandom), 2'($urandom_range(3)), 7'($urandom_range(127)),
                              rand_stops(), rand_stops());
      endcase
      steady = (p == 1);
      // long receiver hold-off while the sender keeps offering items
      if (p == 2) stall_request = 1'b1;
      repeat (7) queue_item(rand_item());
      wait_idle();
    end
    steady = 1'b0;

    // Compress with stops at columns eight and 127: flush and tab at and past the last stop
    apply_config(MODE_COMPRESS, STOP_BITMAP, 7'd8, 64'h100, 64'h8000_0000_0000_0000);
    queue_char(CHAR_TAB);
    queue_char(CHAR_TAB);
    repeat (2) queue_char(CHAR_SPACE);
    queue_char(8'h62);
    queue_char(CHAR_TAB);
    queue_item(tsec_in_t'{CMD_EOL, 8'h55});
    wait_idle();

    // Expand with only the last stop: reach it, tab from it, then drop a tab past the bitmap
    apply_config(MODE_EXPAND, STOP_BITMAP, 7'd8, '0, 64'h8000_0000_0000_0000);
    queue_char(CHAR_TAB);
    queue_char(CHAR_TAB);
    queue_char(CHAR_TAB);
    queue_char(8'h79);
    queue_item(tsec_in_t'{CMD_EOL, 8'hAA});
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
